[sv/psvu_pkg.sv]
package psvu_pkg;

  localparam int FRAC_BITS = 16;

  // Arrival threshold is 1e-4 rounded to the fraction grid, never below one LSB.
  localparam int THR_RAW    = ((1 << FRAC_BITS) + 5000) / 10000;
  localparam int ARRIVE_THR = (THR_RAW == 0) ? 1 : THR_RAW;

  localparam int VAL_W   = 32;
  localparam int DIFF_W  = VAL_W + 1;
  localparam int DIST_W  = DIFF_W + 1;
  localparam int LIM_W   = 23;
  localparam int ACC_W   = 23;
  localparam int STEP_W  = 17;
  localparam int IDX_W   = 16;

  localparam int SQ_STEPS = DIFF_W - 1;
  localparam int LEN_LAT  = SQ_STEPS + 3;

  localparam int UQ_W    = FRAC_BITS + 3;
  localparam int CL_QB   = LIM_W;
  localparam int DIV_QB  = (UQ_W > CL_QB) ? UQ_W : CL_QB;
  localparam int CP_W    = VAL_W + LIM_W;
  localparam int DIV_NW  = ((DIFF_W + FRAC_BITS) > CP_W) ? (DIFF_W + FRAC_BITS) : CP_W;
  localparam int DIV_LAT = DIV_QB + 1;

  localparam int KP_W  = ACC_W + STEP_W;
  localparam int K_W   = KP_W - FRAC_BITS;
  localparam int INC_W = DIV_QB + K_W - FRAC_BITS;
  localparam int SUM_W = ((INC_W > VAL_W) ? INC_W : VAL_W) + 2;

  localparam int QPTR_W = 2;
  localparam int QDEPTH = 1 << QPTR_W;

  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET_X    = 3'd0,
    REG_TARGET_Y    = 3'd1,
    REG_TARGET_Z    = 3'd2,
    REG_ACCEL_RATE  = 3'd3,
    REG_SPEED_LIMIT = 3'd4,
    REG_TIME_STEP   = 3'd5
  } cfg_reg_t;

  localparam logic [ACC_W-1:0]  ACCEL_RST = 23'd65536;
  localparam logic [LIM_W-1:0]  LIMIT_RST = 23'd655360;
  localparam logic [STEP_W-1:0] STEP_RST  = 17'd1092;

  typedef struct packed {
    logic [IDX_W-1:0]        particle_index;
    logic signed [VAL_W-1:0] pos_x;
    logic signed [VAL_W-1:0] pos_y;
    logic signed [VAL_W-1:0] pos_z;
    logic signed [VAL_W-1:0] vel_in_x;
    logic signed [VAL_W-1:0] vel_in_y;
    logic signed [VAL_W-1:0] vel_in_z;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]        index_out;
    logic signed [VAL_W-1:0] vel_out_x;
    logic signed [VAL_W-1:0] vel_out_y;
    logic signed [VAL_W-1:0] vel_out_z;
    logic                    at_target;
    logic                    speed_clamped;
  } out_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] target_x;
    logic signed [VAL_W-1:0] target_y;
    logic signed [VAL_W-1:0] target_z;
    logic [LIM_W-1:0]        speed_limit;
    logic [K_W-1:0]          k;
  } cfg_t;

  typedef struct packed {
    logic [IDX_W-1:0]         index;
    logic signed [VAL_W-1:0]  vel_x;
    logic signed [VAL_W-1:0]  vel_y;
    logic signed [VAL_W-1:0]  vel_z;
    logic signed [DIFF_W-1:0] d_x;
    logic signed [DIFF_W-1:0] d_y;
    logic signed [DIFF_W-1:0] d_z;
    logic [DIST_W-1:0]        dlen;
    logic                     arrived;
  } fq_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

[sv/particle_seek_velocity_update_core.sv]
// Channel  Dir  Handshake             Payload
// in       in   in_valid / in_stall   psvu_pkg::in_item_t, one particle request
// out      out  out_valid / out_stall psvu_pkg::out_item_t, one result per request
// cfg      in   cfg_write             cfg_index, cfg_data (write only)
//
// Sustained rate is one request per cycle while out_stall stays low; the path runs
// through the two length units (35 stages each, with one root bit per root stage)
// and the two divider banks (24 stages each, one quotient bit per divide stage).
// Reset is synchronous, clears control and config state only; no clearing pass.
// The front stalls its input only when the queue is full; the back end freezes
// while a finished result waits on out_stall.
module particle_seek_velocity_update_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  psvu_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output psvu_pkg::out_item_t                 out_data,
  input  logic                                cfg_write,
  input  logic [psvu_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [psvu_pkg::VAL_W-1:0]          cfg_data
);

  logic signed [psvu_pkg::VAL_W-1:0] target_x, target_y, target_z;
  logic [psvu_pkg::ACC_W-1:0]        accel_rate;
  logic [psvu_pkg::LIM_W-1:0]        speed_limit;
  logic [psvu_pkg::STEP_W-1:0]       time_step;
  logic [psvu_pkg::KP_W-1:0]         kp;
  logic [psvu_pkg::K_W-1:0]          k;
  psvu_pkg::cfg_t                    cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_x    <= '0;
      target_y    <= '0;
      target_z    <= '0;
      accel_rate  <= psvu_pkg::ACCEL_RST;
      speed_limit <= psvu_pkg::LIMIT_RST;
      time_step   <= psvu_pkg::STEP_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        psvu_pkg::REG_TARGET_X:    target_x    <= cfg_data;
        psvu_pkg::REG_TARGET_Y:    target_y    <= cfg_data;
        psvu_pkg::REG_TARGET_Z:    target_z    <= cfg_data;
        psvu_pkg::REG_ACCEL_RATE:  accel_rate  <= cfg_data[psvu_pkg::ACC_W-1:0];
        psvu_pkg::REG_SPEED_LIMIT: speed_limit <= cfg_data[psvu_pkg::LIM_W-1:0];
        psvu_pkg::REG_TIME_STEP:   time_step   <= cfg_data[psvu_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Step factor depends on configuration only, so it is formed once here.
  assign kp = psvu_pkg::KP_W'(accel_rate) * psvu_pkg::KP_W'(time_step);

  always_ff @(posedge clk) begin
    k <= kp[psvu_pkg::KP_W-1:psvu_pkg::FRAC_BITS];
  end

  always_comb begin
    cfg.target_x    = target_x;
    cfg.target_y    = target_y;
    cfg.target_z    = target_z;
    cfg.speed_limit = speed_limit;
    cfg.k           = k;
  end

  logic                q_push, q_pop;
  psvu_pkg::fq_item_t  fq_item, q_item;
  psvu_pkg::q_status_t q_st;

  psvu_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .cfg      (cfg),
    .q_st     (q_st),
    .fq_push  (q_push),
    .fq_item  (fq_item)
  );

  psvu_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (q_push),
    .din  (fq_item),
    .pop  (q_pop),
    .dout (q_item),
    .q_st (q_st)
  );

  psvu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_st      (q_st),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_st.full |-> !q_push)
    else $error("request pushed into a full queue");

  a_no_pop_on_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !q_pop)
    else $error("queue popped while the output is held");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    q_st.empty |-> !q_pop)
    else $error("queue popped while empty");

  a_flag_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.at_target && out_data.speed_clamped))
    else $error("arrived request reported as clamped");
`endif

endmodule

[sv/psvu_len.sv]
module psvu_len (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic signed [psvu_pkg::DIFF_W-1:0]   a,
  input  logic signed [psvu_pkg::DIFF_W-1:0]   b,
  input  logic signed [psvu_pkg::DIFF_W-1:0]   c,
  output logic        [psvu_pkg::DIST_W-1:0]   len
);

  localparam int DW = psvu_pkg::DIFF_W;
  localparam int MW = DW - 2;
  localparam int SW = 2 * MW;
  localparam int NW = SW + 2;
  localparam int RW = psvu_pkg::DIST_W;
  localparam int QW = psvu_pkg::SQ_STEPS;

  typedef struct packed {
    logic [NW-1:0] n;
    logic [RW-1:0] r;
    logic [QW-1:0] q;
    logic [1:0]    s;
  } sqst_t;

  function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] v);
    return v[DW-1] ? DW'(-v) : DW'(v);
  endfunction

  // One root bit per stage, classic digit-by-digit square root.
  function automatic sqst_t sq_step(input sqst_t x);
    logic [RW+1:0] trial;
    logic [RW+1:0] test;
    sqst_t         y;
    trial = {x.r, x.n[NW-1:NW-2]};
    test  = (RW+2)'({x.q, 2'b01});
    y     = x;
    y.n   = {x.n[NW-3:0], 2'b00};
    if (trial >= test) begin
      y.r = RW'(trial - test);
      y.q = {x.q[QW-2:0], 1'b1};
    end else begin
      y.r = trial[RW-1:0];
      y.q = {x.q[QW-2:0], 1'b0};
    end
    return y;
  endfunction

  logic [DW-1:0] ma, mb, mc, mx;
  logic [1:0]    s_c;
  logic [MW-1:0] sa_a, sa_b, sa_c;
  logic [1:0]    s_a, s_b;
  logic [SW-1:0] sq_a, sq_b, sq_c;
  sqst_t         st [0:QW];

  // Pre-shift keeps every squared component below 2^62 so the sum fits 64 bits.
  always_comb begin
    ma = mag(a);
    mb = mag(b);
    mc = mag(c);
    mx = ma;
    if (mb > mx) mx = mb;
    if (mc > mx) mx = mc;
    if (mx[DW-1]) begin
      s_c = 2'd2;
    end else if (mx[DW-2]) begin
      s_c = 2'd1;
    end else begin
      s_c = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sa_a <= MW'(ma >> s_c);
      sa_b <= MW'(mb >> s_c);
      sa_c <= MW'(mc >> s_c);
      s_a  <= s_c;
      sq_a <= SW'(sa_a) * SW'(sa_a);
      sq_b <= SW'(sa_b) * SW'(sa_b);
      sq_c <= SW'(sa_c) * SW'(sa_c);
      s_b  <= s_a;
      st[0].n <= NW'(sq_a) + NW'(sq_b) + NW'(sq_c);
      st[0].r <= '0;
      st[0].q <= '0;
      st[0].s <= s_b;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_sq
    always_ff @(posedge clk) begin
      if (en) begin
        st[k+1] <= sq_step(st[k]);
      end
    end
  end

  assign len = {{(RW-QW){1'b0}}, st[QW].q} << st[QW].s;

endmodule

[sv/psvu_div.sv]
module psvu_div (
  input  logic                          clk,
  input  logic                          en,
  input  logic [psvu_pkg::DIV_NW-1:0]   num,
  input  logic [psvu_pkg::DIST_W-1:0]   den,
  output logic [psvu_pkg::DIV_QB-1:0]   quo
);

  localparam int PW = psvu_pkg::DIST_W;
  localparam int QB = psvu_pkg::DIV_QB;
  localparam int NW = psvu_pkg::DIV_NW;

  typedef struct packed {
    logic [PW-1:0] p;
    logic [QB-1:0] low;
    logic [PW-1:0] d;
    logic [QB-1:0] q;
  } dvst_t;

  // Restoring division, one quotient bit per stage. The quotient is known to
  // fit QB bits whenever the result is used.
  function automatic dvst_t dv_step(input dvst_t x);
    logic [PW:0] trial;
    dvst_t       y;
    trial = {x.p, x.low[QB-1]};
    y     = x;
    y.low = {x.low[QB-2:0], 1'b0};
    if (trial >= {1'b0, x.d}) begin
      y.p = PW'(trial - {1'b0, x.d});
      y.q = {x.q[QB-2:0], 1'b1};
    end else begin
      y.p = trial[PW-1:0];
      y.q = {x.q[QB-2:0], 1'b0};
    end
    return y;
  endfunction

  dvst_t st [0:QB];

  always_ff @(posedge clk) begin
    if (en) begin
      st[0].p   <= PW'(num[NW-1:QB]);
      st[0].low <= num[QB-1:0];
      st[0].d   <= den;
      st[0].q   <= '0;
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_dv
    always_ff @(posedge clk) begin
      if (en) begin
        st[k+1] <= dv_step(st[k]);
      end
    end
  end

  assign quo = st[QB].q;

endmodule

[sv/psvu_front.sv]
module psvu_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  psvu_pkg::in_item_t    in_data,
  input  psvu_pkg::cfg_t        cfg,
  input  psvu_pkg::q_status_t   q_st,
  output logic                  fq_push,
  output psvu_pkg::fq_item_t    fq_item
);

  localparam int LAT = psvu_pkg::LEN_LAT;
  localparam int DW  = psvu_pkg::DIFF_W;

  typedef struct packed {
    logic [psvu_pkg::IDX_W-1:0]        index;
    logic signed [psvu_pkg::VAL_W-1:0] vel_x;
    logic signed [psvu_pkg::VAL_W-1:0] vel_y;
    logic signed [psvu_pkg::VAL_W-1:0] vel_z;
    logic signed [DW-1:0]              d_x;
    logic signed [DW-1:0]              d_y;
    logic signed [DW-1:0]              d_z;
  } fside_t;

  logic                       f_en;
  logic                       v0;
  psvu_pkg::in_item_t         in_r;
  logic signed [DW-1:0]       dx, dy, dz;
  logic [psvu_pkg::DIST_W-1:0] dlen;
  logic [LAT-1:0]             sval;
  fside_t                     side [0:LAT-1];

  // The whole front pipeline freezes only when a finished request finds the queue full.
  assign f_en     = !(sval[LAT-1] && q_st.full);
  assign in_stall = !f_en;
  assign fq_push  = sval[LAT-1] && f_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0   <= 1'b0;
      sval <= '0;
    end else if (f_en) begin
      v0   <= in_valid;
      sval <= {sval[LAT-2:0], v0};
    end
  end

  always_ff @(posedge clk) begin
    if (f_en) begin
      in_r    <= in_data;
      side[0] <= '{index: in_r.particle_index, vel_x: in_r.vel_in_x, vel_y: in_r.vel_in_y,
                   vel_z: in_r.vel_in_z, d_x: dx, d_y: dy, d_z: dz};
      for (int i = 1; i < LAT; i++) begin
        side[i] <= side[i-1];
      end
    end
  end

  assign dx = DW'(cfg.target_x) - DW'(in_r.pos_x);
  assign dy = DW'(cfg.target_y) - DW'(in_r.pos_y);
  assign dz = DW'(cfg.target_z) - DW'(in_r.pos_z);

  psvu_len u_len (
    .clk (clk),
    .en  (f_en),
    .a   (dx),
    .b   (dy),
    .c   (dz),
    .len (dlen)
  );

  always_comb begin
    fq_item.index   = side[LAT-1].index;
    fq_item.vel_x   = side[LAT-1].vel_x;
    fq_item.vel_y   = side[LAT-1].vel_y;
    fq_item.vel_z   = side[LAT-1].vel_z;
    fq_item.d_x     = side[LAT-1].d_x;
    fq_item.d_y     = side[LAT-1].d_y;
    fq_item.d_z     = side[LAT-1].d_z;
    fq_item.dlen    = dlen;
    fq_item.arrived = dlen < psvu_pkg::DIST_W'(psvu_pkg::ARRIVE_THR);
  end

endmodule

[sv/psvu_queue.sv]
module psvu_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  psvu_pkg::fq_item_t    din,
  input  logic                  pop,
  output psvu_pkg::fq_item_t    dout,
  output psvu_pkg::q_status_t   q_st
);

  localparam int PW = psvu_pkg::QPTR_W;

  psvu_pkg::fq_item_t mem [0:psvu_pkg::QDEPTH-1];
  logic [PW-1:0]      wp, rp;
  logic [PW:0]        cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop)  rp <= rp + 1'b1;
      cnt <= cnt + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= din;
    end
  end

  assign dout       = mem[rp];
  assign q_st.full  = cnt == (PW+1)'(psvu_pkg::QDEPTH);
  assign q_st.empty = cnt == '0;

endmodule

[sv/psvu_back.sv]
module psvu_back (
  input  logic                  clk,
  input  logic                  rst,
  input  psvu_pkg::cfg_t        cfg,
  input  psvu_pkg::q_status_t   q_st,
  input  psvu_pkg::fq_item_t    q_item,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output psvu_pkg::out_item_t   out_data
);

  localparam int VW   = psvu_pkg::VAL_W;
  localparam int DW   = psvu_pkg::DIFF_W;
  localparam int NW   = psvu_pkg::DIV_NW;
  localparam int QB   = psvu_pkg::DIV_QB;
  localparam int FB   = psvu_pkg::FRAC_BITS;
  localparam int PRW  = QB + psvu_pkg::K_W;
  localparam int IW   = psvu_pkg::INC_W;
  localparam int SW   = psvu_pkg::SUM_W;
  localparam int CPW  = psvu_pkg::CP_W;
  localparam int DLAT = psvu_pkg::DIV_LAT;
  localparam int LLAT = psvu_pkg::LEN_LAT;

  typedef struct packed {
    logic [psvu_pkg::IDX_W-1:0] index;
    logic signed [VW-1:0]       vel_x;
    logic signed [VW-1:0]       vel_y;
    logic signed [VW-1:0]       vel_z;
    logic signed [VW-1:0]       nv_x;
    logic signed [VW-1:0]       nv_y;
    logic signed [VW-1:0]       nv_z;
    logic                       arrived;
  } vn_item_t;

  typedef struct packed {
    vn_item_t v;
    logic     clamp;
  } cl_item_t;

  function automatic logic [DW-1:0] mag_d(input logic signed [DW-1:0] v);
    return v[DW-1] ? DW'(-v) : DW'(v);
  endfunction

  function automatic logic [VW-1:0] mag_v(input logic signed [VW-1:0] v);
    return v[VW-1] ? VW'(-v) : VW'(v);
  endfunction

  function automatic logic signed [VW-1:0] sat(input logic signed [SW-1:0] x);
    if ((&x[SW-1:VW-1]) || !(|x[SW-1:VW-1])) begin
      return x[VW-1:0];
    end else if (x[SW-1]) begin
      return {1'b1, {(VW-1){1'b0}}};
    end else begin
      return {1'b0, {(VW-1){1'b1}}};
    end
  endfunction

  function automatic logic signed [VW-1:0] steer(input logic signed [VW-1:0] vel,
                                                 input logic              neg,
                                                 input logic [IW-1:0]     inc);
    logic signed [SW-1:0] ev;
    logic signed [SW-1:0] ei;
    ev = SW'(vel);
    ei = $signed(SW'(inc));
    return neg ? sat(ev - ei) : sat(ev + ei);
  endfunction

  function automatic logic signed [VW-1:0] apply_sign(input logic signed [VW-1:0] ref_v,
                                                      input logic [QB-1:0]      q);
    logic signed [VW-1:0] m;
    m = $signed(VW'(q));
    return ref_v[VW-1] ? -m : m;
  endfunction

  logic en;
  assign en    = !(out_valid && out_stall);
  assign q_pop = en && !q_st.empty;

  // Head of the back end: request taken from the queue.
  logic               b0v;
  psvu_pkg::fq_item_t b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      b0v <= 1'b0;
    end else if (en) begin
      b0v <= !q_st.empty;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b0 <= q_item;
    end
  end

  // Unit direction: |d| scaled by the fraction, divided by the distance.
  logic [QB-1:0] ux, uy, uz;

  psvu_div u_div_ux (.clk(clk), .en(en), .num(NW'(mag_d(b0.d_x)) << FB), .den(b0.dlen),
                     .quo(ux));
  psvu_div u_div_uy (.clk(clk), .en(en), .num(NW'(mag_d(b0.d_y)) << FB), .den(b0.dlen),
                     .quo(uy));
  psvu_div u_div_uz (.clk(clk), .en(en), .num(NW'(mag_d(b0.d_z)) << FB), .den(b0.dlen),
                     .quo(uz));

  logic [DLAT-1:0]    s1v;
  psvu_pkg::fq_item_t s1 [0:DLAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1v <= '0;
    end else if (en) begin
      s1v <= {s1v[DLAT-2:0], b0v};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1[0] <= b0;
      for (int i = 1; i < DLAT; i++) begin
        s1[i] <= s1[i-1];
      end
    end
  end

  // Increment magnitude: u times the step factor.
  logic [PRW-1:0]     pux, puy, puz;
  logic               m1v;
  psvu_pkg::fq_item_t m1;
  logic [IW-1:0]      inc_x, inc_y, inc_z;

  assign pux = PRW'(ux) * PRW'(cfg.k);
  assign puy = PRW'(uy) * PRW'(cfg.k);
  assign puz = PRW'(uz) * PRW'(cfg.k);

  always_ff @(posedge clk) begin
    if (rst) begin
      m1v <= 1'b0;
    end else if (en) begin
      m1v <= s1v[DLAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1    <= s1[DLAT-1];
      inc_x <= pux[PRW-1:FB];
      inc_y <= puy[PRW-1:FB];
      inc_z <= puz[PRW-1:FB];
    end
  end

  // Saturating velocity update.
  logic     a2v;
  vn_item_t a2;

  always_ff @(posedge clk) begin
    if (rst) begin
      a2v <= 1'b0;
    end else if (en) begin
      a2v <= m1v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a2.index   <= m1.index;
      a2.vel_x   <= m1.vel_x;
      a2.vel_y   <= m1.vel_y;
      a2.vel_z   <= m1.vel_z;
      a2.nv_x    <= steer(m1.vel_x, m1.d_x[DW-1], inc_x);
      a2.nv_y    <= steer(m1.vel_y, m1.d_y[DW-1], inc_y);
      a2.nv_z    <= steer(m1.vel_z, m1.d_z[DW-1], inc_z);
      a2.arrived <= m1.arrived;
    end
  end

  // Speed of the new velocity.
  logic [psvu_pkg::DIST_W-1:0] spd;

  psvu_len u_len_spd (
    .clk (clk),
    .en  (en),
    .a   (DW'(a2.nv_x)),
    .b   (DW'(a2.nv_y)),
    .c   (DW'(a2.nv_z)),
    .len (spd)
  );

  logic [LLAT-1:0] s2v;
  vn_item_t        s2 [0:LLAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      s2v <= '0;
    end else if (en) begin
      s2v <= {s2v[LLAT-2:0], a2v};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2[0] <= a2;
      for (int i = 1; i < LLAT; i++) begin
        s2[i] <= s2[i-1];
      end
    end
  end

  // Clamp decision and numerators |v| * limit.
  logic                        c3v;
  cl_item_t                    c3;
  logic [CPW-1:0]              cpx, cpy, cpz;
  logic [psvu_pkg::DIST_W-1:0] c3_spd;

  always_ff @(posedge clk) begin
    if (rst) begin
      c3v <= 1'b0;
    end else if (en) begin
      c3v <= s2v[LLAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c3.v     <= s2[LLAT-1];
      c3.clamp <= spd > psvu_pkg::DIST_W'(cfg.speed_limit);
      c3_spd   <= spd;
      cpx      <= CPW'(mag_v(s2[LLAT-1].nv_x)) * CPW'(cfg.speed_limit);
      cpy      <= CPW'(mag_v(s2[LLAT-1].nv_y)) * CPW'(cfg.speed_limit);
      cpz      <= CPW'(mag_v(s2[LLAT-1].nv_z)) * CPW'(cfg.speed_limit);
    end
  end

  logic [QB-1:0] rx, ry, rz;

  psvu_div u_div_cx (.clk(clk), .en(en), .num(NW'(cpx)), .den(c3_spd), .quo(rx));
  psvu_div u_div_cy (.clk(clk), .en(en), .num(NW'(cpy)), .den(c3_spd), .quo(ry));
  psvu_div u_div_cz (.clk(clk), .en(en), .num(NW'(cpz)), .den(c3_spd), .quo(rz));

  logic [DLAT-1:0] s3v;
  cl_item_t        s3 [0:DLAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      s3v <= '0;
    end else if (en) begin
      s3v <= {s3v[DLAT-2:0], c3v};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3[0] <= c3;
      for (int i = 1; i < DLAT; i++) begin
        s3[i] <= s3[i-1];
      end
    end
  end

  // Result selection into the output register.
  psvu_pkg::out_item_t res;
  cl_item_t            tl;

  always_comb begin
    tl = s3[DLAT-1];
    res.index_out = tl.v.index;
    if (tl.v.arrived) begin
      res.vel_out_x     = tl.v.vel_x;
      res.vel_out_y     = tl.v.vel_y;
      res.vel_out_z     = tl.v.vel_z;
      res.at_target     = 1'b1;
      res.speed_clamped = 1'b0;
    end else if (tl.clamp) begin
      res.vel_out_x     = apply_sign(tl.v.nv_x, rx);
      res.vel_out_y     = apply_sign(tl.v.nv_y, ry);
      res.vel_out_z     = apply_sign(tl.v.nv_z, rz);
      res.at_target     = 1'b0;
      res.speed_clamped = 1'b1;
    end else begin
      res.vel_out_x     = tl.v.nv_x;
      res.vel_out_y     = tl.v.nv_y;
      res.vel_out_z     = tl.v.nv_z;
      res.at_target     = 1'b0;
      res.speed_clamped = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= s3v[DLAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= res;
    end
  end

endmodule
